@@ design/blis_pkg.sv @@
`timescale 1ns / 1ps
package blis_pkg;

  localparam int DATA_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;
  localparam int POS_W     = 7;
  localparam int DEPTH_DEF = 64;

  // Match flags examined per scan cycle, and the index width within that group.
  localparam int SCAN_LANES = 8;
  localparam int LANE_IDX_W = $clog2(SCAN_LANES);

  localparam int IN_TDATA_W  = ((ACT_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + 2 * POS_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic shift;   // insert at front: every cell takes its left neighbor's value
    logic append;  // insert at end: the cell at the current length loads the value
    logic search;  // every cell compares its value with the key
    logic step;    // match flags move SCAN_LANES cells toward the front
  } blis_ctl_t;

endpackage

@@ design/bounded_list_insert_search.sv @@
`timescale 1ns / 1ps
// Bounded list of up to DEPTH signed 32-bit values with insert at either end
// and search for the first entry equal to a key.
// Requests arrive on the in_ stream: action (insert at front, insert at end,
// or search) and value. Every request yields exactly one result on the out_
// stream carrying status, the 1-based match position and the list length.
// A new request may follow an accepted insert in the next cycle, so inserts run
// at one per cycle while the receiver keeps up. A search compares every cell with
// the key in the accept cycle, then walks the match flags toward the front eight
// cells per cycle; a longer list keeps it busy longer, and it ends sooner when the
// match lies near the front. The scan group width of the match chain sets the
// step of that walk. With the output free, out_tvalid rises once the result of
// an insert, of a search of the empty list, or of the scan cycle that ends any
// other search has passed the result register and then the output register.
// Results pass through a result register and an output register, so one
// further request is taken while a finished result waits for out_tready;
// after that in_tready stays low until the receiver drains the output.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; stored values are not cleared and need not be.
module bounded_list_insert_search import blis_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] action, [33:2] value, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [2:0] status, [9:3] position, [16:10] length
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // Control state.
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic             res_v_r, res_v_nxt;
  logic             out_valid_r;

  // Result payload.
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic [POS_W-1:0]  res_len_r, res_len_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic              accept, res_move, res_free, res_load, full;
  logic [ACT_W-1:0]  in_action;
  logic [DATA_W-1:0] in_value;
  blis_ctl_t         ctl;

  logic [DATA_W-1:0]     cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [SCAN_LANES-1:0] lanes;
  logic                  hit;
  logic [LANE_IDX_W-1:0] hit_idx;
  logic [EXT_W-1:0]      hit_pos, count_ext, count_inc_ext;
  logic                  scan_end;

  assign in_action = in_tdata[ACT_W-1:0];
  assign in_value  = in_tdata[ACT_W+DATA_W-1:ACT_W];

  assign full     = count_r == CNT_W'(DEPTH);
  assign res_move = res_v_r && (!out_valid_r || out_tready);
  assign res_free = !res_v_r || res_move;
  assign in_tready = (state_r == S_IDLE) && res_free;
  assign accept   = in_tvalid && in_tready;

  // The chain of cells: cell 0 holds the front entry.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic              next_m;
    if (g == 0) begin : g_first
      assign prev_d = in_value;
    end else begin : g_rest
      assign prev_d = cell_data[g-1];
    end
    if (g + SCAN_LANES < DEPTH) begin : g_mnext
      assign next_m = cell_match[g+SCAN_LANES];
    end else begin : g_mlast
      assign next_m = 1'b0;
    end
    blis_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .in_val    (in_value),
      .prev_data (prev_d),
      .match_in  (next_m),
      .data_out  (cell_data[g]),
      .match_out (cell_match[g])
    );
  end

  // The front SCAN_LANES cells form the scan window.
  for (genvar l = 0; l < SCAN_LANES; l++) begin : g_lane
    if (l < DEPTH) begin : g_real
      assign lanes[l] = cell_match[l];
    end else begin : g_pad
      assign lanes[l] = 1'b0;
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int l = SCAN_LANES - 1; l >= 0; l--) begin
      if (lanes[l]) begin
        hit     = 1'b1;
        hit_idx = LANE_IDX_W'(l);
      end
    end
  end

  assign hit_pos       = EXT_W'(base_r) + EXT_W'(hit_idx) + EXT_W'(1);
  assign scan_end      = (EXT_W'(base_r) + EXT_W'(SCAN_LANES)) >= EXT_W'(count_r);
  assign count_ext     = EXT_W'(count_r);
  assign count_inc_ext = EXT_W'(count_r) + EXT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    base_nxt     = base_r;
    res_load     = 1'b0;
    res_stat_nxt = res_stat_r;
    res_pos_nxt  = res_pos_r;
    res_len_nxt  = res_len_r;
    ctl          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_load    = 1'b1;
          res_pos_nxt = '0;
          res_len_nxt = count_ext[POS_W-1:0];
          if (in_action[1]) begin
            // Search; an unused action code also lands here.
            if (count_r == '0) begin
              res_stat_nxt = STAT_EMPTY;
            end else begin
              res_load   = 1'b0;
              ctl.search = 1'b1;
              base_nxt   = '0;
              state_nxt  = S_SCAN;
            end
          end else if (full) begin
            res_stat_nxt = STAT_FULL;
          end else begin
            ctl.shift    = in_action == ACT_FRONT;
            ctl.append   = in_action == ACT_END;
            count_nxt    = count_r + CNT_W'(1);
            res_stat_nxt = STAT_INSERTED;
            res_len_nxt  = count_inc_ext[POS_W-1:0];
          end
        end
      end
      S_SCAN: begin
        if (res_free) begin
          res_len_nxt = count_ext[POS_W-1:0];
          if (hit) begin
            res_load     = 1'b1;
            res_stat_nxt = STAT_FOUND;
            res_pos_nxt  = hit_pos[POS_W-1:0];
            state_nxt    = S_IDLE;
          end else if (scan_end) begin
            res_load     = 1'b1;
            res_stat_nxt = STAT_NOT_FOUND;
            res_pos_nxt  = '0;
            state_nxt    = S_IDLE;
          end else begin
            ctl.step = 1'b1;
            base_nxt = base_r + CNT_W'(SCAN_LANES);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_v_nxt = res_load ? 1'b1 : (res_move ? 1'b0 : res_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      base_r  <= base_nxt;
      res_v_r <= res_v_nxt;
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_stat_r <= res_stat_nxt;
    res_pos_r  <= res_pos_nxt;
    res_len_r  <= res_len_nxt;
    if (res_move) begin
      out_data_r <= OUT_TDATA_W'({res_len_r, res_pos_r, res_stat_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // No request is taken while a search scan is running.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !in_tready)
    else $error("request accepted during search scan");

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // An accepted insert into a list that is not full grows it by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_action[1] && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  // A found position lies inside the list: it is never zero.
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && (res_stat_r == STAT_FOUND) |-> (res_pos_r != '0))
    else $error("found result with zero position");

endmodule

@@ design/blis_cell.sv @@
`timescale 1ns / 1ps
module blis_cell import blis_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  blis_ctl_t         ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic [DATA_W-1:0] in_val,
  input  logic [DATA_W-1:0] prev_data,
  input  logic              match_in,
  output logic [DATA_W-1:0] data_out,
  output logic              match_out
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic              match_r;
  logic              occupied;

  assign occupied = IDX_C < count;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= prev_data;
    end else if (ctl.append && (IDX_C == count)) begin
      data_r <= in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.search) begin
      match_r <= occupied && (data_r == in_val);
    end else if (ctl.step) begin
      match_r <= match_in;
    end
  end

  assign data_out  = data_r;
  assign match_out = match_r;

endmodule
